// ===== rtl/indexed_list_engine_defines.svh =====
// ---------------------------------------------------------------------------
// Indexed list engine assertion macros
// Shared concurrent assertion forms for the engine checker.
// ---------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ILE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("ile assertion failed");

// next-cycle implication, disabled in reset
`define ILE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("ile assertion failed");

`endif

// ===== rtl/ile_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ile_pkg
// Types, codes and sizes shared by the indexed list engine.
// ---------------------------------------------------------------------------
package ile_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;

    typedef enum logic [2:0] {
        FN_READ     = 3'd0,
        FN_INS_HEAD = 3'd1,
        FN_INS_TAIL = 3'd2,
        FN_INS_POS  = 3'd3,
        FN_DELETE   = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // how a decoded request gets finished
    typedef enum logic [1:0] {
        K_RESP = 2'd0,
        K_READ = 2'd1,
        K_INS  = 2'd2,
        K_DEL  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ_WAIT,
        S_SHIFT,
        S_FLUSH,
        S_WR_NEW
    } t_state;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [7:0]  position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [6:0]         entry_count;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic rd_pos;
        logic rd_idx;
        logic wr_new;
        logic cnt_inc;
        logic cnt_dec;
        logic respond;
        logic rd_from_ram;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  shift;
        logic  at_last;
    } t_stat;

endpackage

// ===== rtl/ile_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ile_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ile_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ile_ctrl
// Sequencer for the list engine: dispatch, shift loop, final write, respond.
// ---------------------------------------------------------------------------
module ile_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ile_pkg::t_stat i_stat,
    output ile_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    ile_pkg::t_state r_state;
    ile_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ile_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ile_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ile_pkg::S_DISPATCH;
                end
            end
            ile_pkg::S_DISPATCH: begin
                case (i_stat.kind)
                    ile_pkg::K_READ: begin
                        o_cmd.rd_pos = 1'b1;
                        n_state      = ile_pkg::S_READ_WAIT;
                    end
                    ile_pkg::K_INS: begin
                        if (i_stat.shift) begin
                            n_state = ile_pkg::S_SHIFT;
                        end else begin
                            o_cmd.wr_new  = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                            o_cmd.respond = 1'b1;
                            n_state       = ile_pkg::S_IDLE;
                        end
                    end
                    ile_pkg::K_DEL: begin
                        if (i_stat.shift) begin
                            n_state = ile_pkg::S_SHIFT;
                        end else begin
                            o_cmd.cnt_dec = 1'b1;
                            o_cmd.respond = 1'b1;
                            n_state       = ile_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        o_cmd.respond = 1'b1;
                        n_state       = ile_pkg::S_IDLE;
                    end
                endcase
            end
            ile_pkg::S_READ_WAIT: begin
                o_cmd.respond     = 1'b1;
                o_cmd.rd_from_ram = 1'b1;
                n_state           = ile_pkg::S_IDLE;
            end
            ile_pkg::S_SHIFT: begin
                o_cmd.rd_idx = 1'b1;
                if (i_stat.at_last) begin
                    n_state = ile_pkg::S_FLUSH;
                end
            end
            ile_pkg::S_FLUSH: begin
                // last moved entry is written by the datapath this cycle
                if (i_stat.kind == ile_pkg::K_INS) begin
                    n_state = ile_pkg::S_WR_NEW;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.respond = 1'b1;
                    n_state       = ile_pkg::S_IDLE;
                end
            end
            ile_pkg::S_WR_NEW: begin
                o_cmd.wr_new  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.respond = 1'b1;
                n_state       = ile_pkg::S_IDLE;
            end
            default: begin
                n_state = ile_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ile_pkg::S_IDLE);

endmodule

// ===== rtl/ile_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ile_dp
// Datapath: request decode, entry store, shift pointers, count, result regs.
// ---------------------------------------------------------------------------
module ile_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ile_pkg::t_req  i_req,
    input  ile_pkg::t_cmd  i_cmd,
    output ile_pkg::t_stat o_stat,
    output ile_pkg::t_rsp  o_rsp,
    output logic           o_done
);

    localparam int AW = ile_pkg::ADDR_W;
    localparam int CW = ile_pkg::CNT_W;
    localparam int PW = ile_pkg::CMP_W;

    // request registers
    ile_pkg::t_kind     r_kind;
    logic [1:0]         r_status;
    logic signed [31:0] r_rd_imm;
    logic signed [31:0] r_value;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_last;
    logic               r_shift;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;

    // one moved entry in flight between read and write
    logic               r_pend_v;
    logic [AW-1:0]      r_pend_addr;

    ile_pkg::t_rsp      r_rsp;
    logic               r_done;

    // decode results
    ile_pkg::t_kind     d_kind;
    logic [1:0]         d_status;
    logic signed [31:0] d_rd_imm;
    logic [AW-1:0]      d_pos;
    logic [AW-1:0]      d_idx;
    logic [AW-1:0]      d_last;
    logic               d_shift;

    logic               pos_neg;
    logic [PW-1:0]      pos_u;
    logic [PW-1:0]      cnt_u;
    logic [PW-1:0]      ins_pos;
    logic               full;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;

    assign pos_neg = i_req.position[7];
    assign pos_u   = PW'(i_req.position[6:0]);
    assign cnt_u   = PW'(r_count);
    assign full    = (r_count == CW'(ile_pkg::CAPACITY));

    always_comb begin
        d_kind   = ile_pkg::K_RESP;
        d_status = ile_pkg::ST_DONE;
        d_rd_imm = '0;
        d_pos    = AW'(pos_u);
        d_idx    = AW'(r_count - CW'(1));
        d_last   = AW'(pos_u);
        d_shift  = 1'b0;
        ins_pos  = '0;
        case (i_req.func)
            ile_pkg::FN_READ: begin
                if (pos_neg || (pos_u >= cnt_u)) begin
                    d_status = ile_pkg::ST_RANGE;
                    d_rd_imm = -32'sd1;
                end else begin
                    d_kind = ile_pkg::K_READ;
                end
            end
            ile_pkg::FN_INS_HEAD, ile_pkg::FN_INS_TAIL, ile_pkg::FN_INS_POS: begin
                if (i_req.func == ile_pkg::FN_INS_TAIL) begin
                    ins_pos = cnt_u;
                end else if (i_req.func == ile_pkg::FN_INS_POS && !pos_neg) begin
                    ins_pos = pos_u;
                end
                if (ins_pos > cnt_u) begin
                    d_status = ile_pkg::ST_RANGE;
                end else if (full) begin
                    d_status = ile_pkg::ST_FULL;
                end else begin
                    d_kind  = ile_pkg::K_INS;
                    d_pos   = AW'(ins_pos);
                    d_last  = AW'(ins_pos);
                    d_idx   = AW'(r_count - CW'(1));
                    d_shift = (ins_pos != cnt_u);
                end
            end
            ile_pkg::FN_DELETE: begin
                if (pos_neg || (pos_u >= cnt_u)) begin
                    d_status = ile_pkg::ST_RANGE;
                end else begin
                    d_kind  = ile_pkg::K_DEL;
                    d_idx   = AW'(pos_u + PW'(1));
                    d_last  = AW'(r_count - CW'(1));
                    d_shift = ((pos_u + PW'(1)) != cnt_u);
                end
            end
            default: begin
                d_kind = ile_pkg::K_RESP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= d_kind;
            r_status <= d_status;
            r_rd_imm <= d_rd_imm;
            r_pos    <= d_pos;
            r_last   <= d_last;
            r_shift  <= d_shift;
            r_value  <= i_req.value;
        end
        if (i_cmd.load) begin
            r_idx <= d_idx;
        end else if (i_cmd.rd_idx) begin
            r_idx <= (r_kind == ile_pkg::K_INS) ? r_idx - AW'(1) : r_idx + AW'(1);
        end
        if (i_cmd.rd_idx) begin
            r_pend_addr <= (r_kind == ile_pkg::K_INS) ? r_idx + AW'(1) : r_idx - AW'(1);
        end
        if (i_cmd.respond) begin
            r_rsp.read_value  <= i_cmd.rd_from_ram ? ram_rdata : r_rd_imm;
            r_rsp.status      <= r_status;
            r_rsp.entry_count <= 7'(n_count);
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_pend_v <= i_cmd.rd_idx;
            r_done   <= i_cmd.respond;
        end
    end

    // moved entry has priority; the new value is written only once the store is quiet
    assign ram_we    = r_pend_v || i_cmd.wr_new;
    assign ram_waddr = r_pend_v ? r_pend_addr : r_pos;
    assign ram_wdata = r_pend_v ? ram_rdata : r_value;
    assign ram_re    = i_cmd.rd_pos || i_cmd.rd_idx;
    assign ram_raddr = i_cmd.rd_pos ? r_pos : r_idx;

    ile_ram #(
        .WIDTH (32),
        .DEPTH (ile_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_stat.kind    = r_kind;
    assign o_stat.shift   = r_shift;
    assign o_stat.at_last = (r_idx == r_last);
    assign o_rsp          = r_rsp;
    assign o_done         = r_done;

endmodule

// ===== rtl/indexed_list_engine.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of signed 32-bit values with read, insert and delete by index.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_req (func, position, value) and raise start.
//   The item is taken at a clock edge with start high and busy low;
//   busy then stays high until the result is issued.
//   Result channel: o_rsp holds read_value, status and entry_count, flagged
//   by o_done for exactly one cycle. The receiver cannot stall, so it
//   must sample o_rsp whenever o_done is high.
// Sequence after acceptance:
//   a read hit reads the store and answers from its registered read data;
//   refused or ignored requests and unknown codes answer from the decode;
//   an insert or a delete with entries to move first runs the shift loop,
//   and an insert that is not refused writes the new value last. Up to
//   CAPACITY - 1 entries shift, one per cycle through the single read and
//   single write port of the store. A new item can be accepted in the cycle o_done is high.
// Reset (synchronous, active low) empties the list: count goes to zero and
// the sequencer returns to idle. The entry store itself is not cleared;
// only entries below the count are ever read.
// ---------------------------------------------------------------------------
module indexed_list_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ile_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output ile_pkg::t_rsp o_rsp
);

    ile_pkg::t_cmd  cmd;
    ile_pkg::t_stat stat;

    // sequencer: decides when to read, shift, write and respond
    ile_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // decode, store, count and result registers
    ile_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_rsp   (o_rsp),
        .o_done  (o_done)
    );

endmodule

// ===== rtl/ile_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ile_checker
// Port-level checks on the indexed list engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "indexed_list_engine_defines.svh"

module ile_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input ile_pkg::t_rsp o_rsp
);

    // an accepted item always holds the engine busy next cycle
    `ILE_ASSERT_NXT(a_accept_busy, start && !busy, busy)

    // each item gives one result; results never come back to back
    `ILE_ASSERT_NXT(a_done_single, o_done, !o_done)

    // a result only leaves a busy engine
    `ILE_ASSERT_IMP(a_done_busy, o_done, $past(busy))

    // a refused insert leaves a full list and reads as zero
    `ILE_ASSERT_IMP(a_full_rsp, o_done && (o_rsp.status == ile_pkg::ST_FULL), (o_rsp.read_value == 32'sd0) && (o_rsp.entry_count == 7'(ile_pkg::CAPACITY)))

endmodule

bind indexed_list_engine ile_checker u_ile_checker (.*);
